// ----- hw/rtl/contact_impulse_resolver_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the contact impulse resolver
// Concurrent checks clocked on the rising edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CONTACT_IMPULSE_RESOLVER_UNIT_ASSERT_SVH
`define CONTACT_IMPULSE_RESOLVER_UNIT_ASSERT_SVH

// same-cycle implication
`define CIR_ASSERT_IMPLY(lbl, ck, rst_n, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (a) |-> (b)) \
		else $error("resolver check failed: same-cycle implication");

// next-cycle implication
`define CIR_ASSERT_NEXT(lbl, ck, rst_n, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (a) |=> (b)) \
		else $error("resolver check failed: next-cycle implication");

`endif

// ----- hw/rtl/cir_pkg.sv -----
// ----------------------------------------------------------------------------
// cir_pkg
// Widths, request types and arithmetic helpers of the contact impulse resolver.
// ----------------------------------------------------------------------------
package cir_pkg;

	localparam int COMPONENT_BITS = 16;
	localparam int CB    = COMPONENT_BITS;
	localparam int VW    = 3 * CB;        // packed vector
	localparam int NFRAC = CB - 2;        // normal fraction bits
	localparam int IMW   = 16;
	localparam int BW    = 9;
	localparam int PENW  = 16;
	localparam int TOTW  = IMW + 1;       // total inverse mass
	localparam int EW    = BW + 1;        // bounciness, 9 fraction bits
	localparam int PW    = 2 * CB + 1;    // lane velocity product
	localparam int SW    = PW + 2;        // dot product
	localparam int NPW   = CB + PENW;     // normal times penetration
	localparam int NPIW  = NPW + IMW + 1; // times inverse mass
	localparam int SEW   = SW + EW + 1;   // dot product times bounciness
	localparam int QW    = CB + 6;        // quotient bits, divider depth
	localparam int DVW   = QW;            // velocity delta scalar
	localparam int DIVN  = DVW + IMW + 1; // dividend bits
	localparam int LANES = 3;
	localparam int NDIV  = 2 + 2 * LANES;
	localparam int VPW   = QW + 1 + CB;   // scalar times normal
	localparam int SATW  = VPW + 1;

	localparam logic signed [SATW-1:0] SAT_HI = SATW'((64'd1 << (CB - 1)) - 64'd1);
	localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

	typedef struct packed {
		logic [VW-1:0]   normal_vec;
		logic [VW-1:0]   velocity_one;
		logic [VW-1:0]   velocity_two;
		logic [VW-1:0]   accel_one;
		logic [VW-1:0]   accel_two;
		logic [IMW-1:0]  inv_mass_one;
		logic [IMW-1:0]  inv_mass_two;
		logic [BW-1:0]   bounce_one;
		logic [BW-1:0]   bounce_two;
		logic            has_partner;
		logic signed [PENW-1:0] penetration;
	} contact_t;

	typedef struct packed {
		logic [VW-1:0] vel_delta_one;
		logic [VW-1:0] vel_delta_two;
		logic [VW-1:0] move_delta_one;
		logic [VW-1:0] move_delta_two;
		logic          velocity_changed;
		logic          position_changed;
	} result_t;

	// per-lane products
	typedef struct packed {
		logic signed [PW-1:0]  sp;
		logic signed [PW-1:0]  ap;
		logic signed [NPW-1:0] np;
	} lane_t;

	// data riding alongside the divider
	typedef struct packed {
		logic [VW-1:0]    n;
		logic             vchg;
		logic             pchg;
		logic [LANES-1:0] msign1;
		logic [LANES-1:0] msign2;
	} side_t;

	// drop NFRAC fraction bits, nearest, ties away from zero
	function automatic logic signed [SATW-1:0] round_frac(input logic signed [VPW-1:0] p);
		logic [VPW-1:0] mag;
		logic [VPW-1:0] r;
		mag = p[VPW-1] ? VPW'(-p) : VPW'(p);
		r   = VPW'((mag + VPW'(64'd1 << (NFRAC - 1))) >> NFRAC);
		return p[VPW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	// clamp to one signed component
	function automatic logic [CB-1:0] sat_comp(input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] c;
		c = v;
		if (c > SAT_HI) c = SAT_HI;
		if (c < SAT_LO) c = SAT_LO;
		return c[CB-1:0];
	endfunction

endpackage

// ----- hw/rtl/cir_lane.sv -----
// ----------------------------------------------------------------------------
// cir_lane
// One vector component: relative velocity and acceleration times the normal,
// and normal times penetration, registered.
// ----------------------------------------------------------------------------
module cir_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [cir_pkg::CB-1:0]       n,
	input  logic signed [cir_pkg::CB-1:0]       v1,
	input  logic signed [cir_pkg::CB-1:0]       v2,
	input  logic signed [cir_pkg::CB-1:0]       a1,
	input  logic signed [cir_pkg::CB-1:0]       a2,
	input  logic                                partner,
	input  logic signed [cir_pkg::PENW-1:0]     pen,
	output cir_pkg::lane_t                      prod_s1
);

	logic signed [cir_pkg::CB:0] rv;
	logic signed [cir_pkg::CB:0] ra;

	// relative motion, partner ignored for static world
	always_comb begin
		rv = (cir_pkg::CB+1)'(v1) - (partner ? (cir_pkg::CB+1)'(v2) : '0);
		ra = (cir_pkg::CB+1)'(a1) - (partner ? (cir_pkg::CB+1)'(a2) : '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.sp <= rv * n;
			prod_s1.ap <= ra * n;
			prod_s1.np <= n * pen;
		end
	end

endmodule

// ----- hw/rtl/cir_div.sv -----
// ----------------------------------------------------------------------------
// cir_div
// Pipelined restoring divider, one quotient bit per stage, K dividends
// sharing one divisor. Requires dividend < divisor * 2^Q.
// ----------------------------------------------------------------------------
module cir_div #(
	parameter int K = cir_pkg::NDIV,
	parameter int N = cir_pkg::DIVN,
	parameter int D = cir_pkg::TOTW,
	parameter int Q = cir_pkg::QW
) (
	input  logic                clk,
	input  logic [Q-1:0]        adv,
	input  logic [K-1:0][N-1:0] dividend,
	input  logic [D-1:0]        divisor,
	output logic [K-1:0][Q-1:0] quot
);

	logic [D-1:0]        dvs_s [Q];
	logic [K-1:0][D:0]   rem_s [Q];
	logic [K-1:0][Q-1:0] low_s [Q];
	logic [K-1:0][Q-1:0] quo_s [Q];

	logic [D-1:0]        src_dvs [Q];
	logic [K-1:0][D:0]   src_rem [Q];
	logic [K-1:0][Q-1:0] src_low [Q];
	logic [K-1:0][Q-1:0] src_quo [Q];
	logic [K-1:0][D:0]   tsh     [Q];
	logic [K-1:0]        ge      [Q];

	// stage sources: inputs for the first, previous stage otherwise
	always_comb begin
		src_dvs[0] = divisor;
		for (int k = 0; k < K; k++) begin
			src_rem[0][k] = (D+1)'(dividend[k][N-1:Q]);
			src_low[0][k] = dividend[k][Q-1:0];
			src_quo[0][k] = '0;
		end
		for (int j = 1; j < Q; j++) begin
			src_dvs[j] = dvs_s[j-1];
			src_rem[j] = rem_s[j-1];
			src_low[j] = low_s[j-1];
			src_quo[j] = quo_s[j-1];
		end
	end

	// shift in one dividend bit and try the subtract
	always_comb begin
		for (int j = 0; j < Q; j++) begin
			for (int k = 0; k < K; k++) begin
				tsh[j][k] = {src_rem[j][k][D-1:0], src_low[j][k][Q-1]};
				ge[j][k]  = tsh[j][k] >= {1'b0, src_dvs[j]};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < Q; j++) begin
			if (adv[j]) begin
				dvs_s[j] <= src_dvs[j];
				for (int k = 0; k < K; k++) begin
					rem_s[j][k] <= ge[j][k] ? tsh[j][k] - {1'b0, src_dvs[j]} : tsh[j][k];
					low_s[j][k] <= src_low[j][k] << 1;
					quo_s[j][k] <= {src_quo[j][k][Q-2:0], ge[j][k]};
				end
			end
		end
	end

	assign quot = quo_s[Q-1];

endmodule

// ----- hw/rtl/contact_impulse_resolver_unit.sv -----
// ----------------------------------------------------------------------------
// contact_impulse_resolver_unit
// Resolves one particle contact per request: impulse and penetration push-out.
// ----------------------------------------------------------------------------
// Usage:
//   contact channel: contact_valid / contact_stall carry one contact_t request
//   (normal, velocities, accelerations, inverse masses, bounciness, depth).
//   result channel: result_valid / result_stall carry one result_t request
//   with saturated velocity and position deltas and the two change flags.
//   One result per contact, in order.
// Throughput: one contact per cycle unless result_stall holds the pipeline.
//   The depth is set by the shared pipelined divider, one quotient bit per
//   stage over COMPONENT_BITS + 6 bits, plus five front stages (lane
//   products, merge, bounciness, delta scalar, mass products) and two output
//   stages (normal scaling, round/saturate).
// Three component lanes form the products; a merge stage sums them.
// Reset empties the pipeline; no result is pending afterwards.
// Stall: each stage holds while the one after it is full and held, so
//   bubbles close up and contacts are still taken while a result waits.
// ----------------------------------------------------------------------------
`include "contact_impulse_resolver_unit_assert.svh"

module contact_impulse_resolver_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              contact_valid,
	output logic              contact_stall,
	input  cir_pkg::contact_t contact,
	output logic              result_valid,
	input  logic              result_stall,
	output cir_pkg::result_t  result
);

	localparam int CB    = cir_pkg::CB;
	localparam int QW    = cir_pkg::QW;
	localparam int LANES = cir_pkg::LANES;
	localparam int NST   = QW + 7;

	logic [NST:1] vld_s;
	logic [NST:1] rdy;

	// stage handshake: a stage loads when empty or when the next one moves
	always_comb begin
		rdy[NST] = !vld_s[NST] || !result_stall;
		for (int k = NST - 1; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) vld_s[1] <= contact_valid;
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign contact_stall = !rdy[1];
	assign result_valid  = vld_s[NST];

	// stage 1: component lanes and scalar setup
	cir_pkg::lane_t lane_s1 [LANES];

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		cir_lane u_lane (
			.clk     (clk),
			.en      (rdy[1]),
			.n       ($signed(contact.normal_vec[i*CB +: CB])),
			.v1      ($signed(contact.velocity_one[i*CB +: CB])),
			.v2      ($signed(contact.velocity_two[i*CB +: CB])),
			.a1      ($signed(contact.accel_one[i*CB +: CB])),
			.a2      ($signed(contact.accel_two[i*CB +: CB])),
			.partner (contact.has_partner),
			.pen     (contact.penetration),
			.prod_s1 (lane_s1[i])
		);
	end

	logic [cir_pkg::IMW-1:0]  im1_s1, im2_s1;
	logic [cir_pkg::TOTW-1:0] total_s1;
	logic [cir_pkg::EW-1:0]   e_s1;
	logic                     pen_pos_s1;
	logic [cir_pkg::VW-1:0]   n_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			im1_s1     <= contact.inv_mass_one;
			im2_s1     <= contact.has_partner ? contact.inv_mass_two : '0;
			total_s1   <= cir_pkg::TOTW'(contact.inv_mass_one)
				+ (contact.has_partner ? cir_pkg::TOTW'(contact.inv_mass_two) : '0);
			e_s1       <= contact.has_partner
				? cir_pkg::EW'(contact.bounce_one) + cir_pkg::EW'(contact.bounce_two)
				: {contact.bounce_one, 1'b0};
			pen_pos_s1 <= contact.penetration > 0;
			n_s1       <= contact.normal_vec;
		end
	end

	// stage 2: merge lane products; penetration times inverse mass
	logic signed [cir_pkg::SW-1:0]   sep_s2, acc_s2;
	logic signed [cir_pkg::NPIW-1:0] npim1_s2 [LANES];
	logic signed [cir_pkg::NPIW-1:0] npim2_s2 [LANES];
	logic [cir_pkg::IMW-1:0]         im1_s2, im2_s2;
	logic [cir_pkg::TOTW-1:0]        total_s2;
	logic [cir_pkg::EW-1:0]          e_s2;
	logic                            pen_pos_s2;
	logic [cir_pkg::VW-1:0]          n_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			sep_s2 <= cir_pkg::SW'(lane_s1[0].sp) + cir_pkg::SW'(lane_s1[1].sp)
				+ cir_pkg::SW'(lane_s1[2].sp);
			acc_s2 <= cir_pkg::SW'(lane_s1[0].ap) + cir_pkg::SW'(lane_s1[1].ap)
				+ cir_pkg::SW'(lane_s1[2].ap);
			for (int i = 0; i < LANES; i++) begin
				npim1_s2[i] <= lane_s1[i].np * $signed({1'b0, im1_s1});
				npim2_s2[i] <= lane_s1[i].np * $signed({1'b0, im2_s1});
			end
			im1_s2     <= im1_s1;
			im2_s2     <= im2_s1;
			total_s2   <= total_s1;
			e_s2       <= e_s1;
			pen_pos_s2 <= pen_pos_s1;
			n_s2       <= n_s1;
		end
	end

	// stage 3: apply bounciness; prescale push-out dividends
	localparam int MSW = cir_pkg::NPIW + 1;

	logic signed [cir_pkg::SEW-1:0] sepe_s3, acce_s3;
	logic signed [cir_pkg::SW-1:0]  sep_s3;
	logic                           acc_neg_s3, vchg_s3, pchg_s3;
	logic [cir_pkg::IMW-1:0]        im1_s3, im2_s3;
	logic [cir_pkg::TOTW-1:0]       total_s3;
	logic [cir_pkg::VW-1:0]         n_s3;
	logic [cir_pkg::DIVN-1:0]       mdd1_s3 [LANES];
	logic [cir_pkg::DIVN-1:0]       mdd2_s3 [LANES];
	logic [LANES-1:0]               ms1_s3, ms2_s3;
	logic [MSW-1:0]                 md1_sum [LANES];
	logic [MSW-1:0]                 md2_sum [LANES];

	// |x| + total * 2^(NFRAC-1), later shifted by NFRAC
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			md1_sum[i] = MSW'(npim1_s2[i][cir_pkg::NPIW-1] ? -npim1_s2[i] : npim1_s2[i])
				+ (MSW'(total_s2) << (cir_pkg::NFRAC - 1));
			md2_sum[i] = MSW'(npim2_s2[i][cir_pkg::NPIW-1] ? -npim2_s2[i] : npim2_s2[i])
				+ (MSW'(total_s2) << (cir_pkg::NFRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			sepe_s3    <= sep_s2 * $signed({1'b0, e_s2});
			acce_s3    <= acc_s2 * $signed({1'b0, e_s2});
			sep_s3     <= sep_s2;
			acc_neg_s3 <= acc_s2 < 0;
			vchg_s3    <= (sep_s2 < 0) && (total_s2 != '0);
			pchg_s3    <= pen_pos_s2 && (total_s2 != '0);
			for (int i = 0; i < LANES; i++) begin
				mdd1_s3[i] <= cir_pkg::DIVN'(md1_sum[i] >> cir_pkg::NFRAC);
				mdd2_s3[i] <= cir_pkg::DIVN'(md2_sum[i] >> cir_pkg::NFRAC);
				ms1_s3[i]  <= npim1_s2[i][cir_pkg::NPIW-1];
				ms2_s3[i]  <= npim2_s2[i][cir_pkg::NPIW-1];
			end
			im1_s3   <= im1_s2;
			im2_s3   <= im2_s2;
			total_s3 <= total_s2;
			n_s3     <= n_s2;
		end
	end

	// stage 4: target velocity, clamp, rounded delta scalar
	localparam int TGW = cir_pkg::SEW + 3;
	localparam int DLW = cir_pkg::SEW + 4;

	logic signed [TGW-1:0] tg;
	logic signed [DLW-1:0] dl, dvr;

	always_comb begin
		tg = -TGW'(sepe_s3);
		if (acc_neg_s3) begin
			tg = tg + TGW'(acce_s3);
			if (tg < 0) tg = '0;
		end
		dl  = DLW'(tg) - (DLW'(sep_s3) <<< 9);
		dvr = (dl + (DLW'(1) <<< QW)) >>> (CB + 7);
	end

	logic [cir_pkg::DVW-1:0]  dv_s4;
	logic                     vchg_s4, pchg_s4;
	logic [cir_pkg::IMW-1:0]  im1_s4, im2_s4;
	logic [cir_pkg::TOTW-1:0] total_s4;
	logic [cir_pkg::VW-1:0]   n_s4;
	logic [cir_pkg::DIVN-1:0] mdd1_s4 [LANES];
	logic [cir_pkg::DIVN-1:0] mdd2_s4 [LANES];
	logic [LANES-1:0]         ms1_s4, ms2_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			dv_s4    <= cir_pkg::DVW'(dvr);
			vchg_s4  <= vchg_s3;
			pchg_s4  <= pchg_s3;
			im1_s4   <= im1_s3;
			im2_s4   <= im2_s3;
			total_s4 <= total_s3;
			n_s4     <= n_s3;
			mdd1_s4  <= mdd1_s3;
			mdd2_s4  <= mdd2_s3;
			ms1_s4   <= ms1_s3;
			ms2_s4   <= ms2_s3;
		end
	end

	// stage 5: delta scalar times each inverse mass
	logic [cir_pkg::DVW+cir_pkg::IMW-1:0] dvim1_s5, dvim2_s5;
	logic [cir_pkg::TOTW-1:0] total_s5;
	logic [cir_pkg::DIVN-1:0] mdd1_s5 [LANES];
	logic [cir_pkg::DIVN-1:0] mdd2_s5 [LANES];
	cir_pkg::side_t           side_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			dvim1_s5 <= dv_s4 * im1_s4;
			dvim2_s5 <= dv_s4 * im2_s4;
			total_s5 <= total_s4;
			mdd1_s5  <= mdd1_s4;
			mdd2_s5  <= mdd2_s4;
			side_s5.n      <= n_s4;
			side_s5.vchg   <= vchg_s4;
			side_s5.pchg   <= pchg_s4;
			side_s5.msign1 <= ms1_s4;
			side_s5.msign2 <= ms2_s4;
		end
	end

	// stage 6: divide by total inverse mass in the pipelined divider
	logic [cir_pkg::NDIV-1:0][cir_pkg::DIVN-1:0] div_num;
	logic [cir_pkg::NDIV-1:0][QW-1:0]            div_quo;

	always_comb begin
		div_num[0] = cir_pkg::DIVN'(dvim1_s5) + cir_pkg::DIVN'(total_s5 >> 1);
		div_num[1] = cir_pkg::DIVN'(dvim2_s5) + cir_pkg::DIVN'(total_s5 >> 1);
		for (int i = 0; i < LANES; i++) begin
			div_num[2+i]       = mdd1_s5[i];
			div_num[2+LANES+i] = mdd2_s5[i];
		end
	end

	cir_div #(
		.K (cir_pkg::NDIV),
		.N (cir_pkg::DIVN),
		.D (cir_pkg::TOTW),
		.Q (QW)
	) u_div (
		.clk      (clk),
		.adv      (rdy[QW+5:6]),
		.dividend (div_num),
		.divisor  (total_s5),
		.quot     (div_quo)
	);

	cir_pkg::side_t side_s6 [QW];

	always_ff @(posedge clk) begin
		if (rdy[6]) side_s6[0] <= side_s5;
		for (int j = 1; j < QW; j++) begin
			if (rdy[6+j]) side_s6[j] <= side_s6[j-1];
		end
	end

	// stage 7: scale impulse scalars by the normal
	logic signed [cir_pkg::VPW-1:0] vp1_s7 [LANES];
	logic signed [cir_pkg::VPW-1:0] vp2_s7 [LANES];
	logic [QW-1:0]                  mq1_s7 [LANES];
	logic [QW-1:0]                  mq2_s7 [LANES];
	cir_pkg::side_t                 side_s7;

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			for (int i = 0; i < LANES; i++) begin
				vp1_s7[i] <= $signed({1'b0, div_quo[0]})
					* $signed(side_s6[QW-1].n[i*CB +: CB]);
				vp2_s7[i] <= $signed({1'b0, div_quo[1]})
					* $signed(side_s6[QW-1].n[i*CB +: CB]);
				mq1_s7[i] <= div_quo[2+i];
				mq2_s7[i] <= div_quo[2+LANES+i];
			end
			side_s7 <= side_s6[QW-1];
		end
	end

	// stage 8: round, sign, saturate, pack
	cir_pkg::result_t       res_d;
	cir_pkg::result_t       res_s8;
	logic signed [cir_pkg::SATW-1:0] m1v, m2v;

	always_comb begin
		res_d = '0;
		res_d.velocity_changed = side_s7.vchg;
		res_d.position_changed = side_s7.pchg;
		for (int i = 0; i < LANES; i++) begin
			m1v = $signed(cir_pkg::SATW'(mq1_s7[i]));
			m2v = $signed(cir_pkg::SATW'(mq2_s7[i]));
			if (side_s7.vchg) begin
				res_d.vel_delta_one[i*CB +: CB] = cir_pkg::sat_comp(
					cir_pkg::round_frac(vp1_s7[i]));
				res_d.vel_delta_two[i*CB +: CB] = cir_pkg::sat_comp(
					-cir_pkg::round_frac(vp2_s7[i]));
			end
			if (side_s7.pchg) begin
				res_d.move_delta_one[i*CB +: CB] = cir_pkg::sat_comp(
					side_s7.msign1[i] ? -m1v : m1v);
				res_d.move_delta_two[i*CB +: CB] = cir_pkg::sat_comp(
					side_s7.msign2[i] ? m2v : -m2v);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST]) res_s8 <= res_d;
	end

	assign result = res_s8;

	// checks
	`CIR_ASSERT_IMPLY(a_no_impulse_zero, clk, arst_n, result_valid && !result.velocity_changed, result.vel_delta_one == '0 && result.vel_delta_two == '0)
	`CIR_ASSERT_IMPLY(a_no_push_zero, clk, arst_n, result_valid && !result.position_changed, result.move_delta_one == '0 && result.move_delta_two == '0)
	`CIR_ASSERT_IMPLY(a_stall_only_full, clk, arst_n, contact_stall, vld_s[1] && vld_s[NST])
	`CIR_ASSERT_NEXT(a_accept_fills, clk, arst_n, contact_valid && !contact_stall, vld_s[1])

endmodule
